FILE: hw/rtl/obb_pkg.sv
// Shared constants for the oriented box separating axis test unit.
`default_nettype none

package obb_pkg;

  localparam int FIELD_W    = 48;
  localparam int NUM_FIELDS = 12;
  localparam int S_TDATA_W  = FIELD_W * NUM_FIELDS;
  localparam int M_TDATA_W  = 8;
  localparam int NUM_BOX_AX = 6;
  localparam int NUM_AXES   = 15;
  localparam int PIPE_DEPTH = 9;

  // field positions inside the slave tdata
  localparam int F_A_CENTER = 0;
  localparam int F_A_AXIS   = 1;
  localparam int F_A_SIZE   = 4;
  localparam int F_A_SCALE  = 5;
  localparam int F_B_CENTER = 6;
  localparam int F_BOX_STEP = 6;

endpackage

`default_nettype wire

FILE: hw/rtl/obb_prep.sv
// Front end: unpacks both boxes, forms centre difference, half sizes and the 15 test axes.
`default_nettype none

module obb_prep #(
  parameter int CW = 16
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [obb_pkg::S_TDATA_W-1:0]      s_data,
  output logic signed [CW:0]                      ctr_diff [3],
  output logic signed [CW-1:0]                    axes    [obb_pkg::NUM_BOX_AX][3],
  output logic        [2*CW-1:0]                  halves  [obb_pkg::NUM_BOX_AX],
  output logic signed [2*CW:0]                    lvec    [obb_pkg::NUM_AXES][3]
);

  localparam int LW = 2 * CW + 1;

  logic signed [CW-1:0]   comp_c [obb_pkg::NUM_FIELDS][3];

  logic signed [CW:0]     ctr_diff1 [3];
  logic signed [CW-1:0]   axes1  [obb_pkg::NUM_BOX_AX][3];
  logic signed [2*CW-1:0] hprod1 [obb_pkg::NUM_BOX_AX];
  logic signed [2*CW-1:0] cp1    [9][6];

  always_comb begin
    logic [63:0] fx;
    for (int f = 0; f < obb_pkg::NUM_FIELDS; f++) begin
      fx = 64'(s_data[f*obb_pkg::FIELD_W +: obb_pkg::FIELD_W]);
      for (int k = 0; k < 3; k++) begin
        comp_c[f][k] = fx[k*CW +: CW];
      end
    end
  end

  // stage 1: differences and raw products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ctr_diff1[k] <= (CW+1)'(comp_c[obb_pkg::F_A_CENTER][k])
                      - (CW+1)'(comp_c[obb_pkg::F_B_CENTER][k]);
      end
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < 3; k++) begin
            axes1[b*3+i][k] <= comp_c[b*obb_pkg::F_BOX_STEP + obb_pkg::F_A_AXIS + i][k];
          end
          hprod1[b*3+i] <= (2*CW)'(comp_c[b*obb_pkg::F_BOX_STEP + obb_pkg::F_A_SIZE][i])
                         * (2*CW)'(comp_c[b*obb_pkg::F_BOX_STEP + obb_pkg::F_A_SCALE][i]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cp1[i*3+j][0] <= (2*CW)'(comp_c[obb_pkg::F_A_AXIS+i][1])
                         * (2*CW)'(comp_c[obb_pkg::F_B_CENTER+obb_pkg::F_A_AXIS+j][2]);
          cp1[i*3+j][1] <= (2*CW)'(comp_c[obb_pkg::F_A_AXIS+i][2])
                         * (2*CW)'(comp_c[obb_pkg::F_B_CENTER+obb_pkg::F_A_AXIS+j][1]);
          cp1[i*3+j][2] <= (2*CW)'(comp_c[obb_pkg::F_A_AXIS+i][2])
                         * (2*CW)'(comp_c[obb_pkg::F_B_CENTER+obb_pkg::F_A_AXIS+j][0]);
          cp1[i*3+j][3] <= (2*CW)'(comp_c[obb_pkg::F_A_AXIS+i][0])
                         * (2*CW)'(comp_c[obb_pkg::F_B_CENTER+obb_pkg::F_A_AXIS+j][2]);
          cp1[i*3+j][4] <= (2*CW)'(comp_c[obb_pkg::F_A_AXIS+i][0])
                         * (2*CW)'(comp_c[obb_pkg::F_B_CENTER+obb_pkg::F_A_AXIS+j][1]);
          cp1[i*3+j][5] <= (2*CW)'(comp_c[obb_pkg::F_A_AXIS+i][1])
                         * (2*CW)'(comp_c[obb_pkg::F_B_CENTER+obb_pkg::F_A_AXIS+j][0]);
        end
      end
    end
  end

  // stage 2: axes aligned to cross product fraction bits, half sizes as magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      ctr_diff <= ctr_diff1;
      axes <= axes1;
      for (int i = 0; i < obb_pkg::NUM_BOX_AX; i++) begin
        halves[i] <= hprod1[i][2*CW-1] ? (2*CW)'(-hprod1[i]) : hprod1[i];
        for (int k = 0; k < 3; k++) begin
          lvec[i][k] <= LW'(axes1[i][k]) <<< (CW - 2);
        end
      end
      for (int n = 0; n < 9; n++) begin
        lvec[obb_pkg::NUM_BOX_AX+n][0] <= LW'(cp1[n][0]) - LW'(cp1[n][1]);
        lvec[obb_pkg::NUM_BOX_AX+n][1] <= LW'(cp1[n][2]) - LW'(cp1[n][3]);
        lvec[obb_pkg::NUM_BOX_AX+n][2] <= LW'(cp1[n][4]) - LW'(cp1[n][5]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/obb_axis.sv
// Single candidate axis: projections, half-extent sum and separation compare.
`default_nettype none

module obb_axis #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW:0]   ctr_diff [3],
  input  wire logic signed [CW-1:0] axes   [obb_pkg::NUM_BOX_AX][3],
  input  wire logic [2*CW-1:0]      halves [obb_pkg::NUM_BOX_AX],
  input  wire logic signed [2*CW:0] lvec   [3],
  output logic                      sep
);

  localparam int LW   = 2 * CW + 1;
  localparam int PDW  = CW + 1 + LW;
  localparam int PAW  = CW + LW;
  localparam int DW   = PDW + 2;
  localparam int AW   = PAW + 2;
  localparam int AL   = (AW + 1) / 2;
  localparam int AH   = AW - AL;
  localparam int HW   = 2 * CW;
  localparam int MW   = HW + AW;
  localparam int CMPW = 5 * CW + 8;
  localparam int SHL  = 2 * CW - 5;
  localparam int NB   = obb_pkg::NUM_BOX_AX;

  logic signed [PDW-1:0] pd1 [3];
  logic signed [PAW-1:0] pa1 [NB][3];
  logic [HW-1:0]         h1 [NB];
  logic [HW-1:0]         h2 [NB];
  logic [DW-1:0]         left2;
  logic [AW-1:0]         d2 [NB];
  logic [CMPW-1:0]       left3;
  logic [HW+AL-1:0]      mlo3 [NB];
  logic [HW+AH-1:0]      mhi3 [NB];
  logic [CMPW-1:0]       left4;
  logic [MW-1:0]         prod4 [NB];
  logic [CMPW-1:0]       left5;
  logic [CMPW-1:0]       sum5;

  logic signed [DW-1:0]  sd_c;
  logic signed [AW-1:0]  sa_c [NB];
  logic [CMPW-1:0]       sum_c;

  always_comb begin
    sd_c = DW'(pd1[0]) + DW'(pd1[1]) + DW'(pd1[2]);
    for (int i = 0; i < NB; i++) begin
      sa_c[i] = AW'(pa1[i][0]) + AW'(pa1[i][1]) + AW'(pa1[i][2]);
    end
    sum_c = '0;
    for (int i = 0; i < NB; i++) begin
      sum_c = sum_c + CMPW'(prod4[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // T1: dot product terms
      for (int k = 0; k < 3; k++) begin
        pd1[k] <= PDW'(ctr_diff[k]) * PDW'(lvec[k]);
        for (int i = 0; i < NB; i++) begin
          pa1[i][k] <= PAW'(axes[i][k]) * PAW'(lvec[k]);
        end
      end
      h1 <= halves;
      // T2: sums and magnitudes
      left2 <= sd_c[DW-1] ? DW'(-sd_c) : sd_c;
      for (int i = 0; i < NB; i++) begin
        d2[i] <= sa_c[i][AW-1] ? AW'(-sa_c[i]) : sa_c[i];
      end
      h2 <= h1;
      // T3: split half-extent products
      left3 <= CMPW'(left2) << SHL;
      for (int i = 0; i < NB; i++) begin
        mlo3[i] <= (HW+AL)'(h2[i]) * (HW+AL)'(d2[i][AL-1:0]);
        mhi3[i] <= (HW+AH)'(h2[i]) * (HW+AH)'(d2[i][AW-1:AL]);
      end
      // T4: recombine partial products
      left4 <= left3;
      for (int i = 0; i < NB; i++) begin
        prod4[i] <= MW'(mlo3[i]) + (MW'(mhi3[i]) << AL);
      end
      // T5: half-extent sum
      left5 <= left4;
      sum5  <= sum_c;
      // T6: strict compare, touching counts as overlap
      sep   <= left5 > sum5;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/obb_separating_axis_test_unit.sv
// Top level of the oriented box separating axis test unit.
// Input transfer to master-side result passes prep stages 1 and 2, axis stages T1 to T6 and the overlap register.
// Throughput: one box pair per cycle; the whole pipeline advances together and
// holds while a result waits on the master side.
// Reset: synchronous active-high rst clears all valid bits; data registers are not reset.
`default_nettype none

module obb_separating_axis_test_unit #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // a_center, a_axis_x, a_axis_y, a_axis_z, a_size, a_scale,
  // b_center, b_axis_x, b_axis_y, b_axis_z, b_size, b_scale (48 bits each)
  input  wire logic [obb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // overlap, then 7 zero bits
  output logic [obb_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

  localparam int CW = COMPONENT_WIDTH;

  logic                            en;
  logic [obb_pkg::PIPE_DEPTH-1:0]  vld;
  logic                            overlap;

  logic signed [CW:0]              ctr_diff [3];
  logic signed [CW-1:0]            axes   [obb_pkg::NUM_BOX_AX][3];
  logic [2*CW-1:0]                 halves [obb_pkg::NUM_BOX_AX];
  logic signed [2*CW:0]            lvec   [obb_pkg::NUM_AXES][3];
  logic [obb_pkg::NUM_AXES-1:0]    sep;

  assign en            = !vld[obb_pkg::PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[obb_pkg::PIPE_DEPTH-1];
  assign m_axis_tdata  = obb_pkg::M_TDATA_W'(overlap);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[obb_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap <= ~|sep;
    end
  end

  obb_prep #(.CW(CW)) u_prep (
    .clk      (clk),
    .en       (en),
    .s_data   (s_axis_tdata),
    .ctr_diff (ctr_diff),
    .axes     (axes),
    .halves   (halves),
    .lvec     (lvec)
  );

  for (genvar n = 0; n < obb_pkg::NUM_AXES; n++) begin : g_axis
    obb_axis #(.CW(CW)) u_axis (
      .clk      (clk),
      .en       (en),
      .ctr_diff (ctr_diff),
      .axes     (axes),
      .halves   (halves),
      .lvec     (lvec[n]),
      .sep      (sep[n])
    );
  end

endmodule

`default_nettype wire

FILE: hw/rtl/obb_chk.sv
// Port-level checker for the separating axis test unit, with its bind.
`default_nettype none

module obb_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped before transfer");

endmodule

bind obb_separating_axis_test_unit obb_chk u_obb_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

FILE: sim/tb_obb_separating_axis_test_unit.sv
// Self-checking testbench for the oriented box separating axis test unit.
`default_nettype none

module tb_obb_separating_axis_test_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int S_TDATA_W  = obb_pkg::S_TDATA_W;
  localparam int M_TDATA_W  = obb_pkg::M_TDATA_W;
  localparam int FIELD_W    = obb_pkg::FIELD_W;
  localparam int NUM_FIELDS = obb_pkg::NUM_FIELDS;
  localparam int PIPE_DEPTH = obb_pkg::PIPE_DEPTH;
  localparam int F_A_CENTER = obb_pkg::F_A_CENTER;
  localparam int F_B_CENTER = obb_pkg::F_B_CENTER;
  localparam int F_A_AXIS   = obb_pkg::F_A_AXIS;
  localparam int F_A_SIZE   = obb_pkg::F_A_SIZE;
  localparam int F_A_SCALE  = obb_pkg::F_A_SCALE;
  localparam int F_BOX_STEP = obb_pkg::F_BOX_STEP;

  localparam int CW        = 16;
  localparam int N_RANDOM  = 1600;
  localparam int LIMIT     = 400000;
  localparam int DRAIN_AT  = 1300;
  localparam int HOLD_AT   = 200;
  localparam int HOLD_LEN  = 80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  obb_separating_axis_test_unit #(.COMPONENT_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [S_TDATA_W-1:0] pair_q[$];
  bit                   overlap_q[$];
  int                   n_sent = 0, n_errors = 0, n_overlap = 0, n_apart = 0;
  int                   cycles = 0, hold_left = 0;
  bit                   hold_done = 0, s_fire = 0;

  // predictor working set
  longint bx_axis[6][3];
  longint bx_half[6];
  longint ctr_diff[3];

  function automatic logic signed [127:0] abs_dot(longint x0, longint x1, longint x2,
                                                  longint y0, longint y1, longint y2);
    logic signed [127:0] a0, a1, a2, b0, b1, b2, s;
    a0 = x0; a1 = x1; a2 = x2; b0 = y0; b1 = y1; b2 = y2;
    s = a0 * b0 + a1 * b1 + a2 * b2;
    return (s < 0) ? -s : s;
  endfunction

  function automatic bit axis_separates(longint l0, longint l1, longint l2);
    logic signed [127:0] lhs, rhs, h;
    lhs = abs_dot(ctr_diff[0], ctr_diff[1], ctr_diff[2], l0, l1, l2) <<< (2 * CW - 5);
    rhs = 0;
    for (int i = 0; i < 6; i++) begin
      h = bx_half[i];
      rhs += h * abs_dot(bx_axis[i][0], bx_axis[i][1], bx_axis[i][2], l0, l1, l2);
    end
    return lhs > rhs;
  endfunction

  function automatic longint comp_of(logic [S_TDATA_W-1:0] v, int fld, int k);
    logic [FIELD_W-1:0] f;
    f = v[fld * FIELD_W +: FIELD_W];
    return longint'($signed(f[k * CW +: CW]));
  endfunction

  function automatic bit predict_overlap(logic [S_TDATA_W-1:0] v);
    bit sep;
    longint p0, p1, p2, q0, q1, q2;
    sep = 0;
    for (int k = 0; k < 3; k++)
      ctr_diff[k] = comp_of(v, F_A_CENTER, k) - comp_of(v, F_B_CENTER, k);
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++)
          bx_axis[b * 3 + i][k] = comp_of(v, b * F_BOX_STEP + F_A_AXIS + i, k);
        bx_half[b * 3 + i] = comp_of(v, b * F_BOX_STEP + F_A_SIZE, i)
                           * comp_of(v, b * F_BOX_STEP + F_A_SCALE, i);
        if (bx_half[b * 3 + i] < 0) bx_half[b * 3 + i] = -bx_half[b * 3 + i];
      end
    for (int i = 0; i < 6 && !sep; i++)
      sep = axis_separates(bx_axis[i][0] <<< (CW - 2), bx_axis[i][1] <<< (CW - 2),
                           bx_axis[i][2] <<< (CW - 2));
    for (int i = 0; i < 3 && !sep; i++)
      for (int j = 0; j < 3 && !sep; j++) begin
        p0 = bx_axis[i][0]; p1 = bx_axis[i][1]; p2 = bx_axis[i][2];
        q0 = bx_axis[3 + j][0]; q1 = bx_axis[3 + j][1]; q2 = bx_axis[3 + j][2];
        sep = axis_separates(p1 * q2 - p2 * q1, p2 * q0 - p0 * q2, p0 * q1 - p1 * q0);
      end
    return !sep;
  endfunction

  function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  function automatic logic [FIELD_W-1:0] rand_field();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FIELD_W-1:0];
  endfunction

  function automatic int srand(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // one box: signed permutation of the unit frame, optionally skewed
  function automatic logic [6*FIELD_W-1:0] make_box(int cx, int cy, int cz);
    int perm[3], c[3], t, j;
    logic [6*FIELD_W-1:0] bx;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i); t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    bx[0 +: FIELD_W] = pack3(cx, cy, cz);
    for (int i = 0; i < 3; i++) begin
      c = '{0, 0, 0};
      c[perm[i]] = $urandom_range(1) ? 16384 : -16384;
      if ($urandom_range(2) == 0)
        for (int k = 0; k < 3; k++) c[k] += srand(3000);
      bx[(1 + i) * FIELD_W +: FIELD_W] = pack3(c[0], c[1], c[2]);
    end
    for (int k = 0; k < 3; k++) c[k] = $urandom_range(64, 2048);
    bx[4 * FIELD_W +: FIELD_W] = pack3(c[0], c[1], c[2]);
    for (int k = 0; k < 3; k++)
      c[k] = ($urandom_range(7) == 0 ? -1 : 1) * int'($urandom_range(1024, 8192));
    bx[5 * FIELD_W +: FIELD_W] = pack3(c[0], c[1], c[2]);
    return bx;
  endfunction

  function automatic logic [S_TDATA_W-1:0] make_pair();
    logic [S_TDATA_W-1:0] v;
    int ax, ay, az, r;
    if ($urandom_range(4) == 0) begin
      for (int f = 0; f < NUM_FIELDS; f++) v[f * FIELD_W +: FIELD_W] = rand_field();
      return v;
    end
    ax = srand(8000); ay = srand(8000); az = srand(8000);
    r = $urandom_range(100, 3000);
    v[0 +: 6 * FIELD_W] = make_box(ax, ay, az);
    v[6 * FIELD_W +: 6 * FIELD_W] = make_box(ax + srand(r), ay + srand(r), az + srand(r));
    return v;
  endfunction

  // aligned boxes on the unit frame, half size from sz and sc, B centre offset along x
  function automatic logic [S_TDATA_W-1:0] aligned_pair(int dx, int sz, int sc);
    logic [S_TDATA_W-1:0] v;
    for (int b = 0; b < 2; b++) begin
      v[(b * 6 + 0) * FIELD_W +: FIELD_W] = pack3(b * dx, 0, 0);
      v[(b * 6 + 1) * FIELD_W +: FIELD_W] = pack3(16384, 0, 0);
      v[(b * 6 + 2) * FIELD_W +: FIELD_W] = pack3(0, 16384, 0);
      v[(b * 6 + 3) * FIELD_W +: FIELD_W] = pack3(0, 0, 16384);
      v[(b * 6 + 4) * FIELD_W +: FIELD_W] = pack3(sz, sz, sz);
      v[(b * 6 + 5) * FIELD_W +: FIELD_W] = pack3(sc, sc, sc);
    end
    return v;
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || s_fire)) begin
      if (pair_q.size() != 0 &&
          !(n_sent == DRAIN_AT && overlap_q.size() != 0) &&
          $urandom_range(99) >= (n_sent < 550 ? 24 : n_sent < 1100 ? 64 : 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair_q.pop_front();
        n_sent++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= (n_sent < 550 ? 64 : n_sent < 1100 ? 24 : 0);
      end
    end
  end

  // input and result monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    s_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready)
      overlap_q.push_back(predict_overlap(s_axis_tdata));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (overlap_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result transfer, actual overlap %0b", $time, m_axis_tdata[0]);
      end else begin
        if (m_axis_tdata[0] !== overlap_q[0]) begin
          n_errors++;
          $display("%0t: overlap mismatch, expected %0b actual %0b",
                   $time, overlap_q[0], m_axis_tdata[0]);
        end
        if (overlap_q[0]) n_overlap++; else n_apart++;
        void'(overlap_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb_obb_separating_axis_test_unit: errors");
      $finish;
    end
  end

  initial begin
    logic [S_TDATA_W-1:0] v;
    // directed: zeros, all ones, extremes, touching, just apart, sign flips
    pair_q.push_back('0);
    pair_q.push_back('1);
    for (int f = 0; f < NUM_FIELDS; f++) v[f * FIELD_W +: FIELD_W] = pack3(32767, 32767, 32767);
    pair_q.push_back(v);
    for (int f = 0; f < NUM_FIELDS; f++) v[f * FIELD_W +: FIELD_W] = pack3(-32768, -32768, -32768);
    pair_q.push_back(v);
    v[0 +: FIELD_W] = pack3(32767, 32767, 32767);
    pair_q.push_back(v);
    pair_q.push_back(aligned_pair(0, 512, 4096));
    pair_q.push_back(aligned_pair(512, 512, 4096));
    pair_q.push_back(aligned_pair(513, 512, 4096));
    pair_q.push_back(aligned_pair(-513, 512, 4096));
    pair_q.push_back(aligned_pair(512, -512, 4096));
    pair_q.push_back(aligned_pair(513, 512, -4096));
    pair_q.push_back(aligned_pair(600, -512, -4096));
    pair_q.push_back(aligned_pair(513, 1024, 4096));
    v = aligned_pair(700, 512, 4096);
    v[1 * FIELD_W +: FIELD_W] = pack3(32767, 32767, 0);
    pair_q.push_back(v);
    v = aligned_pair(700, 512, 4096);
    v[7 * FIELD_W +: FIELD_W] = pack3(11585, 11585, 0);
    v[8 * FIELD_W +: FIELD_W] = pack3(-11585, 11585, 0);
    pair_q.push_back(v);
    v[6 * FIELD_W +: FIELD_W] = pack3(1400, 1400, 0);
    pair_q.push_back(v);
    for (int i = 0; i < N_RANDOM; i++) pair_q.push_back(make_pair());
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pair_q.size() != 0 || s_axis_tvalid || overlap_q.size() != 0) @(posedge clk);
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    $display("Box pairs sent: %0d, results checked: %0d overlapping, %0d separated",
             n_sent, n_overlap, n_apart);
    $display("Covered both idle mixes, a long output stall and a full drain pause");
    if (n_errors == 0) begin
      $display("tb_obb_separating_axis_test_unit: clean");
    end else begin
      $display("tb_obb_separating_axis_test_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
